### rtl/sbom_pkg.sv
package sbom_pkg;

   // Axis along which boxes are merged.
   typedef enum logic {
      AXIS_X = 1'b0,
      AXIS_Y = 1'b1
   } axis_type;

   // Status of the queue between the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/sbom_front.sv
module sbom_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic                          csr_wdata,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [4*COORD_BITS-1:0]       req_box,
   input  logic                          req_tlast,
   input  sbom_pkg::queue_status_type    queue_status,
   output logic                          push,
   output logic [4*COORD_BITS+1:0]       push_data
);
   import sbom_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0] bottom;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] left;
   } box_type;

   typedef struct packed {
      axis_type axis;
      logic     last;
      box_type  box;
   } entry_type;

   axis_type  merge_axis_ff, merge_axis_in;
   logic      hold_valid_ff, hold_valid_in;
   entry_type hold_entry_ff, hold_entry_in;
   logic      accept;

   assign req_tready = !hold_valid_ff || !queue_status.full;
   assign accept     = req_tvalid && req_tready;
   assign push       = hold_valid_ff && !queue_status.full;
   assign push_data  = hold_entry_ff;

   always_comb begin
      merge_axis_in = merge_axis_ff;
      if (csr_we) begin
         merge_axis_in = axis_type'(csr_wdata);
      end
   end

   // Each transaction is tagged with the axis in force when it was taken.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_entry_in = hold_entry_ff;
      if (accept) begin
         hold_valid_in      = 1'b1;
         hold_entry_in.axis = merge_axis_ff;
         hold_entry_in.last = req_tlast;
         hold_entry_in.box  = box_type'(req_box);
      end else if (push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         merge_axis_ff <= AXIS_X;
         hold_valid_ff <= 1'b0;
      end else begin
         merge_axis_ff <= merge_axis_in;
         hold_valid_ff <= hold_valid_in;
      end
      hold_entry_ff <= hold_entry_in;
   end

endmodule

### rtl/sbom_queue.sv
module sbom_queue #(
   parameter int WIDTH = 66,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output sbom_pkg::queue_status_type queue_status
);
   import sbom_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign queue_status.full  = (count_ff == CNT_W'(DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign pop_data           = slot_ff[rd_ptr_ff];

   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/sbom_back.sv
module sbom_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sbom_pkg::queue_status_type queue_status,
   input  logic [4*COORD_BITS+1:0]    pop_data,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [4*COORD_BITS-1:0]    rsp_box,
   output logic                       rsp_tlast
);
   import sbom_pkg::*;

   typedef struct packed {
      logic [COORD_BITS-1:0] bottom;
      logic [COORD_BITS-1:0] top;
      logic [COORD_BITS-1:0] right;
      logic [COORD_BITS-1:0] left;
   } box_type;

   typedef struct packed {
      axis_type axis;
      logic     last;
      box_type  box;
   } entry_type;

   box_type   held_box_ff, held_box_in;
   logic      held_valid_ff, held_valid_in;
   logic      out_valid_ff, out_valid_in;
   box_type   out_box_ff, out_box_in;
   logic      out_last_ff, out_last_in;
   logic      pend_valid_ff, pend_valid_in;
   box_type   pend_box_ff, pend_box_in;

   entry_type entry;
   box_type   merged_box;
   box_type   next_held;
   logic [COORD_BITS-1:0] held_end;
   logic [COORD_BITS-1:0] box_start;
   logic      overlap;
   logic      emit_held;
   logic      flush;
   logic      out_free;

   assign entry    = entry_type'(pop_data);
   assign out_free = !out_valid_ff || rsp_tready;
   // A second result from the previous box must drain before the next box is taken.
   assign pop      = !queue_status.empty && !pend_valid_ff && out_free;

   assign held_end  = (entry.axis == AXIS_Y) ? held_box_ff.bottom : held_box_ff.right;
   assign box_start = (entry.axis == AXIS_Y) ? entry.box.top : entry.box.left;
   assign overlap   = held_valid_ff && (held_end > box_start);

   // The start on the merge axis is kept; both ends always widen to the larger value.
   always_comb begin
      merged_box = held_box_ff;
      if (entry.box.right > held_box_ff.right) begin
         merged_box.right = entry.box.right;
      end
      if (entry.box.bottom > held_box_ff.bottom) begin
         merged_box.bottom = entry.box.bottom;
      end
      if (entry.axis == AXIS_Y) begin
         if (entry.box.left < held_box_ff.left) begin
            merged_box.left = entry.box.left;
         end
      end else begin
         if (entry.box.top < held_box_ff.top) begin
            merged_box.top = entry.box.top;
         end
      end
   end

   assign next_held = overlap ? merged_box : entry.box;
   assign emit_held = pop && held_valid_ff && !overlap;
   assign flush     = pop && entry.last;

   always_comb begin
      held_box_in   = held_box_ff;
      held_valid_in = held_valid_ff;
      if (pop) begin
         held_box_in   = next_held;
         held_valid_in = !entry.last;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_box_in    = out_box_ff;
      out_last_in   = out_last_ff;
      pend_valid_in = pend_valid_ff;
      pend_box_in   = pend_box_ff;
      if (pop) begin
         if (emit_held) begin
            out_valid_in = 1'b1;
            out_box_in   = held_box_ff;
            out_last_in  = 1'b0;
            if (flush) begin
               pend_valid_in = 1'b1;
               pend_box_in   = next_held;
            end
         end else if (flush) begin
            out_valid_in = 1'b1;
            out_box_in   = next_held;
            out_last_in  = 1'b1;
         end
      end else if (pend_valid_ff && out_free) begin
         out_valid_in  = 1'b1;
         out_box_in    = pend_box_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         held_valid_ff <= held_valid_in;
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
      held_box_ff <= held_box_in;
      out_box_ff  <= out_box_in;
      out_last_ff <= out_last_in;
      pend_box_ff <= pend_box_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_box    = out_box_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/sorted_box_overlap_merge_top.sv
// Merges a stream of bounding boxes that arrive sorted by their start on the
// selected axis. Boxes enter on the req_ channel, one per transaction, with
// req_tlast marking the last box of a set. Merged boxes leave on the rsp_
// channel; rsp_tlast marks the box flushed at the end of a set.
// csr_we with csr_wdata selects the merge axis: 0 along x, 1 along y. It must be
// written only while the block is idle, which the block does not enforce. It
// applies to boxes taken after the write. Throughput: one box per cycle unless
// rsp_ stalls or a second result is pending. A box that overlaps or opens a set
// yields no result unless it also ends the set; a box that ends a set and also
// closes the held box yields two; the second waits in a pending register and the
// back end takes no new box until it has left the single output register. A
// result caused by a box passes through the input register, the queue and the
// output register. A stall on rsp_ fills the output register and then the queue,
// after which req_tready falls; nothing is dropped. Synchronous reset empties the
// queue, discards any held box and pending result, and selects merging along x.
module sorted_box_overlap_merge_top #(
   parameter int  COORD_BITS  = 16,
   parameter int  QUEUE_DEPTH = 4,
   localparam int TDATA_W     = ((4 * COORD_BITS + 7) / 8) * 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic               csr_wdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   // box_left, box_right, box_top, box_bottom, zero fill
   input  logic [TDATA_W-1:0] req_tdata,
   input  logic               req_tlast,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // merged_left, merged_right, merged_top, merged_bottom, zero fill
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);
   import sbom_pkg::*;

   localparam int BOX_W   = 4 * COORD_BITS;
   localparam int ENTRY_W = BOX_W + 2;

   queue_status_type   queue_status;
   logic               push;
   logic [ENTRY_W-1:0] push_data;
   logic               pop;
   logic [ENTRY_W-1:0] pop_data;
   logic [BOX_W-1:0]   rsp_box;

   sbom_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_box     (req_tdata[BOX_W-1:0]),
      .req_tlast   (req_tlast),
      .queue_status(queue_status),
      .push        (push),
      .push_data   (push_data)
   );

   sbom_queue #(
      .WIDTH(ENTRY_W),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_data   (push_data),
      .pop         (pop),
      .pop_data    (pop_data),
      .queue_status(queue_status)
   );

   sbom_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_status(queue_status),
      .pop_data    (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_box     (rsp_box),
      .rsp_tlast   (rsp_tlast)
   );

   always_comb begin
      rsp_tdata            = '0;
      rsp_tdata[BOX_W-1:0] = rsp_box;
   end

endmodule
